FILE: hdl/hwcc_pkg.sv
// Shared types and constants for the hex world coordinate converter.
`default_nettype none
package hwcc_pkg;

    localparam int WORLD_W = 32;
    localparam int HEX_W   = 16;
    localparam int CELL_W  = 16;
    localparam int SPACE_W = 32;
    localparam int PROD_W  = 64;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    typedef enum logic [1:0] {
        REG_X_SPACING     = 2'd0,
        REG_Y_SPACING     = 2'd1,
        REG_INV_X_SPACING = 2'd2,
        REG_INV_Y_SPACING = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ACT_WORLD_TO_HEX = 1'b0,
        ACT_HEX_TO_WORLD = 1'b1
    } t_action;

    typedef struct packed {
        logic [SPACE_W-1:0] x_spacing;
        logic [SPACE_W-1:0] y_spacing;
        logic [SPACE_W-1:0] inv_x_spacing;
        logic [SPACE_W-1:0] inv_y_spacing;
    } t_cfg;

endpackage
`default_nettype wire

FILE: hdl/hwcc_cmd_if.sv
// Input channel carrying one conversion request per beat.
`default_nettype none
interface hwcc_cmd_if;
    import hwcc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [WORLD_W-1:0]  world_x;
    logic signed [WORLD_W-1:0]  world_y;
    logic signed [HEX_W-1:0]    hex_col;
    logic signed [HEX_W-1:0]    hex_row;
    logic                       scale;

    modport source (
        output valid, action, world_x, world_y, hex_col, hex_row, scale,
        input  ready
    );
    modport sink (
        input  valid, action, world_x, world_y, hex_col, hex_row, scale,
        output ready
    );
endinterface
`default_nettype wire

FILE: hdl/hwcc_res_if.sv
// Output channel carrying one conversion result per beat.
`default_nettype none
interface hwcc_res_if;
    import hwcc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [CELL_W-1:0]   cell_col;
    logic signed [CELL_W-1:0]   cell_row;
    logic signed [WORLD_W-1:0]  pos_x;
    logic signed [WORLD_W-1:0]  pos_y;
    logic                       saturated;

    modport source (
        output valid, cell_col, cell_row, pos_x, pos_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, cell_col, cell_row, pos_x, pos_y, saturated,
        output ready
    );
endinterface
`default_nettype wire

FILE: hdl/hwcc_cfg_regs.sv
// APB register file holding the spacing and reciprocal spacing values.
`default_nettype none
module hwcc_cfg_regs #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hwcc_pkg::APB_AW-1:0] paddr,
    input  wire logic [hwcc_pkg::APB_DW-1:0] pwdata,
    output logic      [hwcc_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output hwcc_pkg::t_cfg                   o_cfg
);
    import hwcc_pkg::*;

    localparam logic [SPACE_W-1:0] UNIT = SPACE_W'(1) << FRAC_BITS;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_spacing     <= UNIT;
            r_cfg.y_spacing     <= UNIT;
            r_cfg.inv_x_spacing <= UNIT;
            r_cfg.inv_y_spacing <= UNIT;
        end else if (wr) begin
            unique case (idx)
                REG_X_SPACING:     r_cfg.x_spacing     <= pwdata;
                REG_Y_SPACING:     r_cfg.y_spacing     <= pwdata;
                REG_INV_X_SPACING: r_cfg.inv_x_spacing <= pwdata;
                REG_INV_Y_SPACING: r_cfg.inv_y_spacing <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_X_SPACING:     prdata = r_cfg.x_spacing;
            REG_Y_SPACING:     prdata = r_cfg.y_spacing;
            REG_INV_X_SPACING: prdata = r_cfg.inv_x_spacing;
            REG_INV_Y_SPACING: prdata = r_cfg.inv_y_spacing;
            default:           prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/hwcc_mult_stage.sv
// Input register followed by the two shared multipliers and their product register.
`default_nettype none
module hwcc_mult_stage #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_action,
    input  wire logic signed [hwcc_pkg::WORLD_W-1:0] i_world_x,
    input  wire logic signed [hwcc_pkg::WORLD_W-1:0] i_world_y,
    input  wire logic signed [hwcc_pkg::HEX_W-1:0]   i_hex_col,
    input  wire logic signed [hwcc_pkg::HEX_W-1:0]   i_hex_row,
    input  wire logic                                i_scale,
    input  hwcc_pkg::t_cfg                           i_cfg,
    output logic                                     o_action,
    output logic signed [hwcc_pkg::PROD_W-1:0]       o_prod_a,
    output logic signed [hwcc_pkg::PROD_W-1:0]       o_prod_b
);
    import hwcc_pkg::*;

    localparam int OPW = SPACE_W + 1;
    localparam logic [SPACE_W-1:0] UNIT = SPACE_W'(1) << FRAC_BITS;

    logic                      r_action;
    logic signed [WORLD_W-1:0] r_world_x;
    logic signed [WORLD_W-1:0] r_world_y;
    logic signed [HEX_W-1:0]   r_hex_col;
    logic signed [HEX_W-1:0]   r_hex_row;
    logic                      r_scale;

    logic signed [OPW-1:0]     op_a0, op_a1, op_b0, op_b1;
    logic signed [HEX_W+1:0]   row2;
    logic signed [2*OPW-1:0]   full_a, full_b;

    logic                      r_action_p;
    logic signed [PROD_W-1:0]  r_prod_a;
    logic signed [PROD_W-1:0]  r_prod_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action  <= i_action;
            r_world_x <= i_world_x;
            r_world_y <= i_world_y;
            r_hex_col <= i_hex_col;
            r_hex_row <= i_hex_row;
            r_scale   <= i_scale;
        end
    end

    // The odd-column half step is carried as twice the row plus the column's low bit.
    always_comb begin
        row2 = ((HEX_W+2)'(r_hex_row) <<< 1)
             + $signed({{(HEX_W+1){1'b0}}, r_hex_col[0]});
        if (r_action == ACT_HEX_TO_WORLD) begin
            op_a0 = OPW'(r_hex_col);
            op_b0 = OPW'(row2);
            op_a1 = $signed({1'b0, r_scale ? i_cfg.x_spacing : UNIT});
            op_b1 = $signed({1'b0, r_scale ? i_cfg.y_spacing : UNIT});
        end else begin
            op_a0 = OPW'(r_world_x);
            op_b0 = OPW'(r_world_y);
            op_a1 = $signed({1'b0, i_cfg.inv_x_spacing});
            op_b1 = $signed({1'b0, i_cfg.inv_y_spacing});
        end
        full_a = op_a0 * op_a1;
        full_b = op_b0 * op_b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action_p <= r_action;
            r_prod_a   <= $signed(full_a[PROD_W-1:0]);
            r_prod_b   <= $signed(full_b[PROD_W-1:0]);
        end
    end

    assign o_action = r_action_p;
    assign o_prod_a = r_prod_a;
    assign o_prod_b = r_prod_b;
endmodule
`default_nettype wire

FILE: hdl/hwcc_round_stage.sv
// Cube rounding of the scaled world position and saturation of the world result.
`default_nettype none
module hwcc_round_stage #(
    parameter int FRAC_BITS = 16,
    parameter int IW        = 35
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_action,
    input  wire logic signed [hwcc_pkg::PROD_W-1:0]  i_prod_a,
    input  wire logic signed [hwcc_pkg::PROD_W-1:0]  i_prod_b,
    output logic                                     o_action,
    output logic signed [IW-1:0]                     o_ix,
    output logic signed [IW-1:0]                     o_iy,
    output logic signed [IW-1:0]                     o_iz,
    output logic        [FRAC_BITS:0]                o_ex,
    output logic        [FRAC_BITS:0]                o_ey,
    output logic        [FRAC_BITS:0]                o_ez,
    output logic signed [hwcc_pkg::WORLD_W-1:0]      o_pos_x,
    output logic signed [hwcc_pkg::WORLD_W-1:0]      o_pos_y,
    output logic                                     o_pos_sat
);
    import hwcc_pkg::*;

    localparam int XW = PROD_W - FRAC_BITS;
    localparam int CW = XW + 3;
    localparam int EW = FRAC_BITS + 1;
    localparam logic signed [CW:0]     HALF_V = (CW+1)'(1) <<< FRAC_BITS;
    localparam logic        [EW-1:0]   HALF_E = EW'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] WHI  = PROD_W'({1'b0, {(WORLD_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] WLO  = -WHI - PROD_W'(1);

    // Cube components carry one more fraction bit than the scaled position.
    function automatic logic signed [IW-1:0] rnd_int(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        t = (CW+1)'(v) + HALF_V;
        return $signed(t[CW:FRAC_BITS+1]);
    endfunction

    function automatic logic [EW-1:0] rnd_err(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic        [EW-1:0] m;
        t = (CW+1)'(v) + HALF_V;
        m = t[FRAC_BITS:0];
        return (m >= HALF_E) ? (m - HALF_E) : (HALF_E - m);
    endfunction

    logic signed [XW-1:0]     x, y;
    logic signed [CW-1:0]     cx, cy, cz;
    logic signed [PROD_W-1:0] py_raw;
    logic signed [WORLD_W-1:0] px_c, py_c;
    logic                     px_sat, py_sat;

    logic                     r_action;
    logic signed [IW-1:0]     r_ix, r_iy, r_iz;
    logic        [EW-1:0]     r_ex, r_ey, r_ez;
    logic signed [WORLD_W-1:0] r_pos_x, r_pos_y;
    logic                     r_pos_sat;

    always_comb begin
        x  = $signed(i_prod_a[PROD_W-1:FRAC_BITS]);
        y  = $signed(i_prod_b[PROD_W-1:FRAC_BITS]);
        cx = CW'(x) <<< 1;
        cy = (CW'(y) <<< 1) - CW'(x);
        cz = -CW'(x) - (CW'(y) <<< 1);

        py_raw = i_prod_b >>> 1;
        px_sat = 1'b1;
        py_sat = 1'b1;
        if (i_prod_a > WHI) begin
            px_c = WHI[WORLD_W-1:0];
        end else if (i_prod_a < WLO) begin
            px_c = WLO[WORLD_W-1:0];
        end else begin
            px_c   = i_prod_a[WORLD_W-1:0];
            px_sat = 1'b0;
        end
        if (py_raw > WHI) begin
            py_c = WHI[WORLD_W-1:0];
        end else if (py_raw < WLO) begin
            py_c = WLO[WORLD_W-1:0];
        end else begin
            py_c   = py_raw[WORLD_W-1:0];
            py_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_action  <= i_action;
            r_ix      <= rnd_int(cx);
            r_iy      <= rnd_int(cy);
            r_iz      <= rnd_int(cz);
            r_ex      <= rnd_err(cx);
            r_ey      <= rnd_err(cy);
            r_ez      <= rnd_err(cz);
            r_pos_x   <= px_c;
            r_pos_y   <= py_c;
            r_pos_sat <= px_sat || py_sat;
        end
    end

    assign o_action  = r_action;
    assign o_ix      = r_ix;
    assign o_iy      = r_iy;
    assign o_iz      = r_iz;
    assign o_ex      = r_ex;
    assign o_ey      = r_ey;
    assign o_ez      = r_ez;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_pos_sat = r_pos_sat;
endmodule
`default_nettype wire

FILE: hdl/hwcc_finish_stage.sv
// Cube sum correction, offset column mapping, cell clamping and the result register.
`default_nettype none
module hwcc_finish_stage #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    parameter int IW         = 35
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_action,
    input  wire logic signed [IW-1:0]                i_ix,
    input  wire logic signed [IW-1:0]                i_iy,
    input  wire logic signed [IW-1:0]                i_iz,
    input  wire logic        [FRAC_BITS:0]           i_ex,
    input  wire logic        [FRAC_BITS:0]           i_ey,
    input  wire logic        [FRAC_BITS:0]           i_ez,
    input  wire logic signed [hwcc_pkg::WORLD_W-1:0] i_pos_x,
    input  wire logic signed [hwcc_pkg::WORLD_W-1:0] i_pos_y,
    input  wire logic                                i_pos_sat,
    output logic signed [hwcc_pkg::CELL_W-1:0]       o_cell_col,
    output logic signed [hwcc_pkg::CELL_W-1:0]       o_cell_row,
    output logic signed [hwcc_pkg::WORLD_W-1:0]      o_pos_x,
    output logic signed [hwcc_pkg::WORLD_W-1:0]      o_pos_y,
    output logic                                     o_saturated
);
    import hwcc_pkg::*;

    localparam int WI = (IW + 3 > COORD_BITS + 2) ? IW + 3 : COORD_BITS + 2;
    localparam logic signed [WI-1:0] CHI = WI'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [WI-1:0] CLO = -CHI - WI'(1);

    logic signed [WI-1:0] ix, iy, iz, s, d, t, tr, row;
    logic signed [WI-1:0] col_c, row_c;
    logic                 col_sat, row_sat;

    logic signed [CELL_W-1:0]  r_cell_col, r_cell_row;
    logic signed [WORLD_W-1:0] r_pos_x, r_pos_y;
    logic                      r_saturated;

    always_comb begin
        ix = WI'(i_ix);
        iy = WI'(i_iy);
        iz = WI'(i_iz);
        s  = ix + iy + iz;
        // The rounding error decides which component absorbs a nonzero sum.
        if (s != '0) begin
            if (i_ex >= i_ey && i_ex >= i_ez) begin
                ix = ix - s;
            end else if (i_ey >= i_ex && i_ey >= i_ez) begin
                iy = iy - s;
            end else begin
                iz = iz - s;
            end
        end
        d = iy - iz;
        if (d < 0) begin
            t = d - WI'(1) + $signed({{(WI-1){1'b0}}, ~ix[0]});
        end else begin
            t = d + WI'(1) - $signed({{(WI-1){1'b0}}, ix[0]});
        end
        // Halving that truncates toward zero.
        tr  = t + $signed({{(WI-1){1'b0}}, t[WI-1]});
        row = tr >>> 1;

        col_sat = 1'b1;
        row_sat = 1'b1;
        if (ix > CHI) begin
            col_c = CHI;
        end else if (ix < CLO) begin
            col_c = CLO;
        end else begin
            col_c   = ix;
            col_sat = 1'b0;
        end
        if (row > CHI) begin
            row_c = CHI;
        end else if (row < CLO) begin
            row_c = CLO;
        end else begin
            row_c   = row;
            row_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_action == ACT_HEX_TO_WORLD) begin
                r_cell_col  <= '0;
                r_cell_row  <= '0;
                r_pos_x     <= i_pos_x;
                r_pos_y     <= i_pos_y;
                r_saturated <= i_pos_sat;
            end else begin
                r_cell_col  <= col_c[CELL_W-1:0];
                r_cell_row  <= row_c[CELL_W-1:0];
                r_pos_x     <= '0;
                r_pos_y     <= '0;
                r_saturated <= col_sat || row_sat;
            end
        end
    end

    assign o_cell_col  = r_cell_col;
    assign o_cell_row  = r_cell_row;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_saturated = r_saturated;
endmodule
`default_nettype wire

FILE: hdl/hex_world_coordinate_converter_top.sv
// Top level of the hex world coordinate converter.
// Converts world positions (signed Q16.16 by default) to column-offset hex cells
// and back, one item per beat with no state between items. The datapath is a
// four-register pipeline: input register, multiplier products, cube rounding,
// then the result register. The input register loads at the edge that takes the
// input beat, and the item then passes through the product, rounding and
// result registers in turn before result valid rises. One item is taken every
// cycle while results are drained. The whole pipeline holds only while a result
// waits on the output, which makes the input ready a function of the output
// ready. Spacing registers must be written over the APB port only while no item
// is in flight, which the block does not enforce; their reset value is 1.0.
`default_nettype none
module hex_world_coordinate_converter_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    hwcc_cmd_if.sink                         i_cmd,
    hwcc_res_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hwcc_pkg::APB_AW-1:0] paddr,
    input  wire logic [hwcc_pkg::APB_DW-1:0] pwdata,
    output logic      [hwcc_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import hwcc_pkg::*;

    localparam int IW = PROD_W + 3 - 2 * FRAC_BITS;

    t_cfg cfg;
    logic en;
    logic r_v_in, r_v_prod, r_v_rnd, r_v_out;

    logic                      p_action;
    logic signed [PROD_W-1:0]  p_prod_a, p_prod_b;

    logic                      q_action;
    logic signed [IW-1:0]      q_ix, q_iy, q_iz;
    logic        [FRAC_BITS:0] q_ex, q_ey, q_ez;
    logic signed [WORLD_W-1:0] q_pos_x, q_pos_y;
    logic                      q_pos_sat;

    assign en          = !r_v_out || o_res.ready;
    assign i_cmd.ready = en;
    assign o_res.valid = r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_rnd  <= 1'b0;
            r_v_out  <= 1'b0;
        end else if (en) begin
            r_v_in   <= i_cmd.valid;
            r_v_prod <= r_v_in;
            r_v_rnd  <= r_v_prod;
            r_v_out  <= r_v_rnd;
        end
    end

    hwcc_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hwcc_mult_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_action  (i_cmd.action),
        .i_world_x (i_cmd.world_x),
        .i_world_y (i_cmd.world_y),
        .i_hex_col (i_cmd.hex_col),
        .i_hex_row (i_cmd.hex_row),
        .i_scale   (i_cmd.scale),
        .i_cfg     (cfg),
        .o_action  (p_action),
        .o_prod_a  (p_prod_a),
        .o_prod_b  (p_prod_b)
    );

    hwcc_round_stage #(
        .FRAC_BITS (FRAC_BITS),
        .IW        (IW)
    ) u_round (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_action  (p_action),
        .i_prod_a  (p_prod_a),
        .i_prod_b  (p_prod_b),
        .o_action  (q_action),
        .o_ix      (q_ix),
        .o_iy      (q_iy),
        .o_iz      (q_iz),
        .o_ex      (q_ex),
        .o_ey      (q_ey),
        .o_ez      (q_ez),
        .o_pos_x   (q_pos_x),
        .o_pos_y   (q_pos_y),
        .o_pos_sat (q_pos_sat)
    );

    hwcc_finish_stage #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .IW         (IW)
    ) u_finish (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_action    (q_action),
        .i_ix        (q_ix),
        .i_iy        (q_iy),
        .i_iz        (q_iz),
        .i_ex        (q_ex),
        .i_ey        (q_ey),
        .i_ez        (q_ez),
        .i_pos_x     (q_pos_x),
        .i_pos_y     (q_pos_y),
        .i_pos_sat   (q_pos_sat),
        .o_cell_col  (o_res.cell_col),
        .o_cell_row  (o_res.cell_row),
        .o_pos_x     (o_res.pos_x),
        .o_pos_y     (o_res.pos_y),
        .o_saturated (o_res.saturated)
    );
endmodule
`default_nettype wire

FILE: hdl/hwcc_checker.sv
// Port-level assertions for the converter top level and the bind that attaches them.
`default_nettype none
module hwcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_cell_col,
    input wire logic [15:0] i_cell_row,
    input wire logic [31:0] i_pos_x,
    input wire logic [31:0] i_pos_y,
    input wire logic        i_saturated
);
    // A result beat comes from exactly one direction, so cell and world fields never mix.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_cell_col != 16'd0 || i_cell_row != 16'd0))
        |-> (i_pos_x == 32'd0 && i_pos_y == 32'd0))
        else $error("cell and world results both nonzero");

    // A clamped world result shows up as a range limit in at least one coordinate.
    a_world_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_saturated && (i_pos_x != 32'd0 || i_pos_y != 32'd0))
        |-> (i_pos_x == 32'h7fffffff || i_pos_x == 32'h80000000
             || i_pos_y == 32'h7fffffff || i_pos_y == 32'h80000000))
        else $error("saturated world result not at a range limit");

    // A held result must stall the input side.
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted while output is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_pos_x)
                                          && $stable(i_cell_col)))
        else $error("stalled result beat changed");
endmodule

bind hex_world_coordinate_converter_top hwcc_checker u_hwcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_cell_col  (o_res.cell_col),
    .i_cell_row  (o_res.cell_row),
    .i_pos_x     (o_res.pos_x),
    .i_pos_y     (o_res.pos_y),
    .i_saturated (o_res.saturated)
);
`default_nettype wire
